/* sv/jhds_pkg.sv */
// shared types, codes and marker helpers for the jpeg header dimension scanner
package jhds_pkg;

   localparam logic [7:0] MK_FF   = 8'hFF;
   localparam logic [7:0] MK_SOF0 = 8'hC0;
   localparam logic [7:0] MK_SOF1 = 8'hC1;
   localparam logic [7:0] MK_SOF9 = 8'hC9;
   localparam logic [7:0] MK_RST0 = 8'hD0;
   localparam logic [7:0] MK_RST7 = 8'hD7;
   localparam logic [7:0] MK_SOI  = 8'hD8;
   localparam logic [7:0] MK_EOI  = 8'hD9;
   localparam logic [7:0] MK_SOS  = 8'hDA;
   localparam logic [7:0] MK_TEM  = 8'h01;
   localparam logic [7:0] MK_STUFF = 8'h00;

   localparam logic [15:0] SOF_MIN_LEN = 16'd7;
   localparam logic [15:0] SEG_MIN_LEN = 16'd2;

   typedef enum logic [3:0] {
      PH_FIRST  = 4'd0,
      PH_SOI    = 4'd1,
      PH_HUNT   = 4'd2,
      PH_FILL   = 4'd3,
      PH_LEN_HI = 4'd4,
      PH_LEN_LO = 4'd5,
      PH_SKIP   = 4'd6,
      PH_PREC   = 4'd7,
      PH_H_HI   = 4'd8,
      PH_H_LO   = 4'd9,
      PH_W_HI   = 4'd10,
      PH_W_LO   = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      ST_HUFFMAN    = 3'd0,
      ST_ARITHMETIC = 3'd1,
      ST_END_MARKER = 3'd2,
      ST_NOT_JPEG   = 3'd3,
      ST_BAD_LENGTH = 3'd4
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  marker;
   } result_type;

   function automatic logic is_sof01(input logic [7:0] m);
      return (m == MK_SOF0) || (m == MK_SOF1);
   endfunction

   function automatic logic ends_after_length(input logic [7:0] m);
      return ((m >= 8'hC2) && (m <= 8'hCB) && (m != 8'hC4)) ||
             ((m >= 8'hCD) && (m <= 8'hCF)) || (m == MK_SOS);
   endfunction

endpackage

/* sv/jhds_parser.sv */
// marker parser state and the per-word step logic
module jhds_parser
   import jhds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       file_start,
   output logic       emit,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic        finished_ff, finished_in;
   logic [15:0] skip_ff, skip_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  width_hi_ff, width_hi_in;
   logic [7:0]  marker_ff, marker_in;

   phase_type   phase_cur;
   logic        done_cur;
   logic [15:0] seg_len;

   assign phase_cur = file_start ? PH_FIRST : phase_ff;
   assign done_cur  = file_start ? 1'b0 : finished_ff;
   assign seg_len   = {len_hi_ff, data_byte};

   always_comb begin
      phase_in    = phase_cur;
      finished_in = done_cur;
      skip_in     = skip_ff;
      len_hi_in   = len_hi_ff;
      height_in   = height_ff;
      width_hi_in = width_hi_ff;
      marker_in   = marker_ff;
      emit        = 1'b0;
      result      = '{status: ST_HUFFMAN, width: 16'd0, height: 16'd0, marker: 8'd0};
      if (!done_cur) begin
         unique case (phase_cur)
            PH_FIRST: begin
               if (data_byte != MK_FF) begin
                  emit          = 1'b1;
                  result.status = ST_NOT_JPEG;
                  result.marker = data_byte;
               end else begin
                  phase_in = PH_SOI;
               end
            end
            PH_SOI: begin
               if (data_byte != MK_SOI) begin
                  emit          = 1'b1;
                  result.status = ST_NOT_JPEG;
                  result.marker = data_byte;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_HUNT: begin
               if (data_byte == MK_FF) begin
                  phase_in = PH_FILL;
               end
            end
            PH_FILL: begin
               if (data_byte == MK_FF) begin
                  phase_in = PH_FILL;
               end else if (data_byte == MK_STUFF) begin
                  phase_in = PH_HUNT;
               end else begin
                  marker_in = data_byte;
                  if ((data_byte == MK_SOI) || (data_byte == MK_EOI)) begin
                     emit          = 1'b1;
                     result.status = ST_END_MARKER;
                     result.marker = data_byte;
                  end else if (((data_byte >= MK_RST0) && (data_byte <= MK_RST7)) ||
                               (data_byte == MK_TEM)) begin
                     phase_in = PH_HUNT;
                  end else begin
                     phase_in = PH_LEN_HI;
                  end
               end
            end
            PH_LEN_HI: begin
               len_hi_in = data_byte;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               result.marker = marker_ff;
               if (is_sof01(marker_ff)) begin
                  if (seg_len < SOF_MIN_LEN) begin
                     emit          = 1'b1;
                     result.status = ST_BAD_LENGTH;
                  end else begin
                     phase_in = PH_PREC;
                  end
               end else if (seg_len < SEG_MIN_LEN) begin
                  emit          = 1'b1;
                  result.status = ST_BAD_LENGTH;
               end else if (marker_ff == MK_SOF9) begin
                  emit          = 1'b1;
                  result.status = ST_ARITHMETIC;
               end else if (ends_after_length(marker_ff)) begin
                  emit          = 1'b1;
                  result.status = ST_END_MARKER;
               end else begin
                  skip_in  = seg_len - SEG_MIN_LEN;
                  phase_in = (seg_len == SEG_MIN_LEN) ? PH_HUNT : PH_SKIP;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 16'd1;
               if (skip_ff == 16'd1) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_PREC: begin
               phase_in = PH_H_HI;
            end
            PH_H_HI: begin
               height_in = {data_byte, 8'd0};
               phase_in  = PH_H_LO;
            end
            PH_H_LO: begin
               height_in = {height_ff[15:8], data_byte};
               phase_in  = PH_W_HI;
            end
            PH_W_HI: begin
               width_hi_in = data_byte;
               phase_in    = PH_W_LO;
            end
            PH_W_LO: begin
               emit          = 1'b1;
               result.status = ST_HUFFMAN;
               result.width  = {width_hi_ff, data_byte};
               result.height = height_ff;
               result.marker = marker_ff;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
         if (emit) begin
            finished_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         finished_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         skip_ff     <= skip_in;
         len_hi_ff   <= len_hi_in;
         height_ff   <= height_in;
         width_hi_ff <= width_hi_in;
         marker_ff   <= marker_in;
      end
   end

endmodule

/* sv/jpeg_header_dimension_scanner.sv */
// top level: input register, marker parser and result register
//
// jpeg header dimension scanner
// req channel: one file byte per word (req_data_byte), with req_file_start
// marking the first byte of a new file; the parser restarts on that byte.
// rsp channel: at most one word per file carrying rsp_scan_status,
// rsp_image_width, rsp_image_height and rsp_end_marker. after that word all
// bytes are dropped until the next file start.
// result path: a byte taken into the input register is parsed into the result
// register by the combinational parser step, unless it waits behind a held
// word that the receiver has not taken.
// throughput: one byte per cycle, unless a result byte waits behind a held
// word; the parser step between the two registers is combinational.
// reset: the parser waits for the FF D8 signature of a file, so the first
// file needs no start flag; both registers empty.
// receiver stall: the input register keeps taking bytes that yield no
// result; a byte that would yield one waits while an untaken word is held.
module jpeg_header_dimension_scanner
   import jhds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_scan_status,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [7:0]  rsp_end_marker
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic       emit;
   result_type result;
   logic       advance;

   assign advance   = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   jhds_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .file_start (in_start_ff),
      .emit       (emit),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_file_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scan_status  = rsp_ff.status;
   assign rsp_image_width  = rsp_ff.width;
   assign rsp_image_height = rsp_ff.height;
   assign rsp_end_marker   = rsp_ff.marker;

`ifndef SYNTHESIS
   // dimensions only come with a huffman frame header
   a_dims_only_huffman: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != ST_HUFFMAN) |->
         (rsp_ff.width == 16'd0) && (rsp_ff.height == 16'd0))
      else $error("dimensions reported without a huffman frame header");

   a_huffman_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == ST_HUFFMAN) |->
         (rsp_ff.marker == MK_SOF0) || (rsp_ff.marker == MK_SOF1))
      else $error("huffman status with a marker other than sof0 or sof1");

   // the input side stalls only behind an untaken result word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !req_ready |-> rsp_valid_ff && !rsp_ready && emit)
      else $error("input stalled without a held result word");
`endif

endmodule

/* sim/jpeg_header_dimension_scanner_tb.sv */
// testbench for the jpeg header dimension scanner: byte streams in, at most one checked result word per file
`timescale 1ns / 1ps

module jpeg_header_dimension_scanner_tb;
   import jhds_pkg::*;

   localparam logic [7:0] MK_SOF2 = 8'hC2;
   localparam logic [7:0] MK_DHT  = 8'hC4;
   localparam logic [7:0] MK_JPG  = 8'hC8;
   localparam logic [7:0] MK_DAC  = 8'hCC;
   localparam logic [7:0] MK_APP0 = 8'hE0;
   localparam logic [7:0] MK_COM  = 8'hFE;
   localparam logic [3:0] SOF_FAMILY = 4'hC;

   typedef struct {
      logic [7:0] data;
      logic       start;
      logic       drain;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_file_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_scan_status;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [7:0]  rsp_end_marker;

   stream_byte_type pending_bytes[$];
   result_type      expected_words[$];

   // scan state of the predictor
   phase_type   scan_phase;
   logic [15:0] bytes_left;
   logic [7:0]  len_hi;
   logic [15:0] height_acc;
   logic [7:0]  width_hi;
   logic [7:0]  seg_marker;
   logic        scan_done;

   int mismatch_count = 0;
   int words_checked = 0;
   int bytes_queued = 0;
   int files_built = 0;
   int status_seen[5] = '{default: 0};
   logic drain_next = 1'b0;
   int sender_gap = 0;
   int drain_quiet = 0;
   logic offer_next;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   bit receiver_long_hold = 1'b0;

   jpeg_header_dimension_scanner DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_file_start   (req_file_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scan_status  (rsp_scan_status),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_end_marker   (rsp_end_marker)
   );

   always #4 clock = ~clock;

   function automatic logic carries_dims(input logic [7:0] m);
      return (m == MK_SOF0) || (m == MK_SOF1);
   endfunction

   function automatic logic ends_scan(input logic [7:0] m);
      return ((m[7:4] == SOF_FAMILY) && (m != MK_DHT) && (m != MK_DAC) && !carries_dims(m)) ||
             (m == MK_SOS);
   endfunction

   function automatic logic skippable(input logic [7:0] m);
      return !((m >= MK_RST0) && (m <= MK_RST7)) && (m != MK_SOI) && (m != MK_EOI) &&
             !carries_dims(m) && !ends_scan(m);
   endfunction

   function automatic int idle_length();
      if ($urandom_range(99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // one stretch in four has no idling on either side
   function automatic logic quiet_stretch();
      return (($time / 4000) % 4) == 0;
   endfunction

   task automatic clear_scan_state();
      scan_phase = PH_FIRST;
      bytes_left = '0;
      len_hi = '0;
      height_acc = '0;
      width_hi = '0;
      seg_marker = '0;
      scan_done = 1'b0;
   endtask

   task automatic finish_scan(input status_type st, input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] m);
      result_type r;
      r.status = st;
      r.width = w;
      r.height = h;
      r.marker = m;
      expected_words.push_back(r);
      scan_done = 1'b1;
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic start);
      logic [15:0] seg_len;
      if (start) begin
         clear_scan_state();
      end
      if (scan_done) begin
         return;
      end
      case (scan_phase)
         PH_FIRST: begin
            if (b != MK_FF) finish_scan(ST_NOT_JPEG, 16'd0, 16'd0, b);
            else scan_phase = PH_SOI;
         end
         PH_SOI: begin
            if (b != MK_SOI) finish_scan(ST_NOT_JPEG, 16'd0, 16'd0, b);
            else scan_phase = PH_HUNT;
         end
         PH_HUNT: begin
            if (b == MK_FF) scan_phase = PH_FILL;
         end
         PH_FILL: begin
            if (b == MK_STUFF) begin
               scan_phase = PH_HUNT;
            end else if (b != MK_FF) begin
               seg_marker = b;
               if (b == MK_SOI || b == MK_EOI) finish_scan(ST_END_MARKER, 16'd0, 16'd0, b);
               else if ((b >= MK_RST0 && b <= MK_RST7) || b == MK_TEM) scan_phase = PH_HUNT;
               else scan_phase = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            len_hi = b;
            scan_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            seg_len = {len_hi, b};
            if (carries_dims(seg_marker)) begin
               if (seg_len < SOF_MIN_LEN) finish_scan(ST_BAD_LENGTH, 16'd0, 16'd0, seg_marker);
               else scan_phase = PH_PREC;
            end else if (seg_len < SEG_MIN_LEN) begin
               finish_scan(ST_BAD_LENGTH, 16'd0, 16'd0, seg_marker);
            end else if (seg_marker == MK_SOF9) begin
               finish_scan(ST_ARITHMETIC, 16'd0, 16'd0, seg_marker);
            end else if (ends_scan(seg_marker)) begin
               finish_scan(ST_END_MARKER, 16'd0, 16'd0, seg_marker);
            end else begin
               bytes_left = seg_len - SEG_MIN_LEN;
               if (bytes_left != 0) scan_phase = PH_SKIP;
               else scan_phase = PH_HUNT;
            end
         end
         PH_SKIP: begin
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 0) scan_phase = PH_HUNT;
         end
         PH_PREC: scan_phase = PH_H_HI;
         PH_H_HI: begin
            height_acc = {b, 8'h00};
            scan_phase = PH_H_LO;
         end
         PH_H_LO: begin
            height_acc[7:0] = b;
            scan_phase = PH_W_HI;
         end
         PH_W_HI: begin
            width_hi = b;
            scan_phase = PH_W_LO;
         end
         PH_W_LO: finish_scan(ST_HUFFMAN, {width_hi, b}, height_acc, seg_marker);
         default: scan_phase = PH_HUNT;
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_word();
      result_type want;
      if (expected_words.size() == 0) begin
         report_mismatch($sformatf("word with none expected: status %0d marker %h",
                                   rsp_scan_status, rsp_end_marker));
         return;
      end
      want = expected_words.pop_front();
      words_checked++;
      status_seen[int'(want.status)]++;
      if (rsp_scan_status != want.status)
         report_mismatch($sformatf("status %0d, expected %0d", rsp_scan_status, want.status));
      if (rsp_image_width != want.width)
         report_mismatch($sformatf("width %h, expected %h", rsp_image_width, want.width));
      if (rsp_image_height != want.height)
         report_mismatch($sformatf("height %h, expected %h", rsp_image_height, want.height));
      if (rsp_end_marker != want.marker)
         report_mismatch($sformatf("marker %h, expected %h", rsp_end_marker, want.marker));
   endtask

   // stream building
   task automatic push_byte(input logic [7:0] d, input logic s);
      pending_bytes.push_back('{d, s, drain_next});
      drain_next = 1'b0;
      bytes_queued++;
   endtask

   task automatic push_marker(input logic [7:0] m, input logic [15:0] len);
      push_byte(MK_FF, 1'b0);
      push_byte(m, 1'b0);
      push_byte(len[15:8], 1'b0);
      push_byte(len[7:0], 1'b0);
   endtask

   task automatic push_sof(input logic [7:0] m, input logic [15:0] h, input logic [15:0] w,
                           input logic [15:0] len);
      push_marker(m, len);
      push_byte(8'($urandom_range(255)), 1'b0);
      push_byte(h[15:8], 1'b0);
      push_byte(h[7:0], 1'b0);
      push_byte(w[15:8], 1'b0);
      push_byte(w[7:0], 1'b0);
   endtask

   task automatic open_file();
      push_byte(MK_FF, 1'b1);
      push_byte(MK_SOI, 1'b0);
   endtask

   function automatic logic [7:0] pick_skip_marker();
      logic [7:0] m;
      m = 8'($urandom_range(2, 254));
      while (!skippable(m)) m = 8'($urandom_range(2, 254));
      return m;
   endfunction

   task automatic random_filler();
      int n;
      case ($urandom_range(4))
         0: repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(254)), 1'b0);
         1: begin
            repeat ($urandom_range(1, 3)) push_byte(MK_FF, 1'b0);
            push_byte(($urandom_range(8) == 8) ? MK_TEM : 8'(MK_RST0 + $urandom_range(7)),
                      1'b0);
         end
         2: begin
            push_byte(MK_FF, 1'b0);
            push_byte(MK_STUFF, 1'b0);
         end
         default: begin
            n = $urandom_range(0, 10);
            push_marker(pick_skip_marker(), 16'(n + 2));
            repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
         end
      endcase
   endtask

   task automatic random_ending();
      int pick;
      logic [7:0] m;
      pick = $urandom_range(99);
      if (pick < 45) begin
         push_sof($urandom_range(1) ? MK_SOF1 : MK_SOF0, 16'($urandom_range(65535)),
                  16'($urandom_range(65535)),
                  ($urandom_range(3) != 0) ? 16'd17 : 16'($urandom_range(7, 65535)));
      end else if (pick < 57) begin
         // sof family and sos; the non-terminating codes fold onto sos
         m = 8'(MK_SOF0 + $urandom_range(15));
         if (!ends_scan(m)) m = MK_SOS;
         push_marker(m, 16'($urandom_range(2, 65535)));
      end else if (pick < 65) begin
         push_byte(MK_FF, 1'b0);
         push_byte($urandom_range(1) ? MK_SOI : MK_EOI, 1'b0);
      end else if (pick < 77) begin
         if ($urandom_range(1)) push_marker($urandom_range(1) ? MK_SOF1 : MK_SOF0,
                                            16'($urandom_range(0, 6)));
         else push_marker($urandom_range(1) ? pick_skip_marker() : MK_SOS,
                          16'($urandom_range(0, 1)));
      end else if (pick < 88) begin
         // long segment cut off by the next file
         push_marker(pick_skip_marker(), 16'($urandom_range(2, 65535)));
         repeat ($urandom_range(0, 6)) push_byte(8'($urandom_range(255)), 1'b0);
      end else begin
         push_marker($urandom_range(1) ? MK_SOF1 : MK_SOF0, 16'($urandom_range(7, 65535)));
         repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   task automatic random_file();
      logic [7:0] b;
      files_built++;
      if (files_built % 16 == 0) drain_next = 1'b1;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 24))
            push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
         return;
      end
      if ($urandom_range(99) < 6) begin
         if ($urandom_range(1)) begin
            push_byte(8'($urandom_range(254)), 1'b1);
         end else begin
            b = 8'($urandom_range(255));
            if (b == MK_SOI) b = MK_EOI;
            push_byte(MK_FF, 1'b1);
            push_byte(b, 1'b0);
         end
         return;
      end
      push_byte(MK_FF, $urandom_range(19) != 0);
      push_byte(MK_SOI, 1'b0);
      repeat ($urandom_range(0, 3)) random_filler();
      random_ending();
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)), 1'b0);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer_next = req_valid;
         if (req_valid && req_ready) begin
            void'(pending_bytes.pop_front());
            offer_next = 1'b0;
            if (!quiet_stretch() && $urandom_range(99) < 25) sender_gap = idle_length();
         end
         if (receiver_long_hold) sender_gap = 0;
         drain_quiet = (expected_words.size() == 0) ? drain_quiet + 1 : 0;
         if (!offer_next) begin
            if (sender_gap > 0) begin
               sender_gap--;
            end else if (pending_bytes.size() != 0 &&
                         (!pending_bytes[0].drain || drain_quiet > 4)) begin
               req_data_byte <= pending_bytes[0].data;
               req_file_start <= pending_bytes[0].start;
               offer_next = 1'b1;
            end
         end
         req_valid <= offer_next;
      end
   end

   // receiver, checker and predictor
   always @(posedge clock) begin
      if (reset) begin
         clear_scan_state();
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_word();
         if (req_valid && req_ready) predict_byte(req_data_byte, req_file_start);
         if (hold_left > 0) begin
            hold_left--;
         end else begin
            receiver_long_hold = 1'b0;
            if (!long_hold_done && words_checked >= 30) begin
               long_hold_done = 1'b1;
               receiver_long_hold = 1'b1;
               hold_left = 400;
            end else if (!quiet_stretch() && $urandom_range(99) < 20) begin
               hold_left = idle_length();
            end
         end
         rsp_ready <= (hold_left == 0);
      end
   end

   initial begin
      // first file straight after reset, no start flag
      push_byte(MK_FF, 1'b0);
      push_byte(MK_SOI, 1'b0);
      push_sof(MK_SOF0, 16'd480, 16'd640, 16'd17);
      // ignored after the result, signature included
      push_byte(MK_FF, 1'b0);
      push_byte(MK_SOI, 1'b0);
      push_byte(8'h5A, 1'b0);
      open_file();
      push_sof(MK_SOF1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      open_file();
      push_sof(MK_SOF0, 16'h0000, 16'h0000, SOF_MIN_LEN);
      push_byte(MK_STUFF, 1'b1);
      push_byte(MK_FF, 1'b1);
      push_byte(MK_EOI, 1'b0);
      // junk, fill, stuffing, rst, tem and skipped segments before the frame
      open_file();
      push_byte(8'h12, 1'b0);
      push_byte(8'h34, 1'b0);
      push_byte(MK_FF, 1'b0);
      push_byte(MK_FF, 1'b0);
      push_byte(MK_FF, 1'b0);
      push_byte(MK_RST0, 1'b0);
      push_byte(MK_FF, 1'b0);
      push_byte(MK_STUFF, 1'b0);
      push_byte(MK_FF, 1'b0);
      push_byte(MK_TEM, 1'b0);
      push_byte(MK_FF, 1'b0);
      push_byte(MK_RST7, 1'b0);
      push_marker(MK_APP0, 16'd4);
      push_byte(MK_FF, 1'b0);
      push_byte(MK_EOI, 1'b0);
      push_marker(MK_COM, SEG_MIN_LEN);
      push_marker(MK_DHT, 16'd3);
      push_byte(8'hAA, 1'b0);
      push_marker(MK_DAC, 16'd3);
      push_byte(8'h55, 1'b0);
      push_sof(MK_SOF1, 16'd1, 16'd2, SOF_MIN_LEN);
      open_file();
      push_marker(MK_SOF9, 16'd11);
      open_file();
      push_marker(MK_SOS, 16'd12);
      open_file();
      push_marker(MK_SOF2, SEG_MIN_LEN);
      open_file();
      push_marker(MK_JPG, 16'h0100);
      open_file();
      push_byte(MK_FF, 1'b0);
      push_byte(MK_SOI, 1'b0);
      open_file();
      push_byte(MK_FF, 1'b0);
      push_byte(MK_EOI, 1'b0);
      open_file();
      push_marker(MK_SOF0, 16'd6);
      open_file();
      push_marker(MK_APP0, 16'd1);
      open_file();
      push_marker(MK_SOF1, 16'd0);
      // restart in the middle of a long segment
      open_file();
      push_marker(MK_COM, 16'h8000);
      push_byte(MK_FF, 1'b0);
      push_byte(MK_SOF0, 1'b0);
      open_file();
      push_sof(MK_SOF0, 16'h8001, 16'h7FFE, 16'd17);
      while (bytes_queued < 1100) random_file();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      repeat (4) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d bytes over %0d random files plus directed cases, %0d result words checked",
               bytes_queued, files_built, words_checked);
      $display("huffman %0d, arithmetic %0d, end marker %0d, not jpeg %0d, bad length %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TIMEOUT at %0t", $time);
      $display("Mismatches found");
      $finish;
   end

endmodule
